>>> sv/path_decoration_span_finder_top_macros.svh
// Assertion macros used by the span finder RTL.
`ifndef PATH_DECORATION_SPAN_FINDER_TOP_MACROS_SVH
`define PATH_DECORATION_SPAN_FINDER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PDSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PDSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pdsf_pkg.sv
package pdsf_pkg;

   localparam int DEFAULT_MAX_LEN = 1024;

   localparam int CH_W  = 8;
   localparam int OUT_W = 10;

   localparam logic [CH_W-1:0] CH_NUL       = 8'h00;
   localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CH_W-1:0] CH_DOT       = 8'h2E;
   localparam logic [CH_W-1:0] CH_OPEN      = 8'h5B;
   localparam logic [CH_W-1:0] CH_CLOSE     = 8'h5D;
   localparam logic [CH_W-1:0] CH_DIGIT_LO  = 8'h30;
   localparam logic [CH_W-1:0] CH_DIGIT_HI  = 8'h39;

endpackage

>>> sv/pdsf_req_if.sv
interface pdsf_req_if;
   import pdsf_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

>>> sv/pdsf_rsp_if.sv
interface pdsf_rsp_if;
   import pdsf_pkg::*;

   logic             valid;
   logic             ready;
   logic             removed;
   logic [OUT_W-1:0] cut_start;
   logic [OUT_W-1:0] cut_length;
   logic             too_long;

   modport source (output valid, output removed, output cut_start, output cut_length,
                   output too_long, input ready);
   modport sink   (input valid, input removed, input cut_start, input cut_length,
                   input too_long, output ready);
endinterface

>>> sv/path_decoration_span_finder_top.sv
// The response for a string appears in the cycle after its NUL byte is accepted.
// Throughput: one byte per cycle while the request side is not stalled; the byte
// update and the response are both one register stage.
// A response waiting on the output register stalls the request side only when the
// downstream ready is also low.
// Reset is synchronous and active high; it clears all scan state and the response valid.
module path_decoration_span_finder_top #(
   parameter int MAX_LEN = pdsf_pkg::DEFAULT_MAX_LEN
) (
   input logic        clock,
   input logic        reset,
   pdsf_req_if.sink   req_bus,
   pdsf_rsp_if.source rsp_bus
);
   import pdsf_pkg::*;

   `include "path_decoration_span_finder_top_macros.svh"

   // Index registers must be able to hold MAX_LEN itself, since the position
   // counter saturates there once a string runs too long.
   localparam int PW = $clog2(MAX_LEN + 1);
   localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);

   // Scan state, one copy for the string in flight.
   logic [PW-1:0] position_ff,        position_in;
   logic          overflowed_ff,      overflowed_in;
   logic [PW-1:0] component_start_ff, component_start_in;
   logic          open_active_ff,     open_active_in;
   logic [PW-1:0] open_index_ff,      open_index_in;
   logic          closed_just_now_ff, closed_just_now_in;
   logic [PW-1:0] closed_start_ff,    closed_start_in;
   logic          dot_valid_ff,       dot_valid_in;
   logic          dot_has_group_ff,   dot_has_group_in;
   logic [PW-1:0] dot_group_start_ff, dot_group_start_in;
   logic [PW-1:0] dot_index_ff,       dot_index_in;

   // Response register.
   logic             rsp_valid_ff,  rsp_valid_in;
   logic             removed_ff,    removed_in;
   logic [OUT_W-1:0] cut_start_ff,  cut_start_in;
   logic [OUT_W-1:0] cut_length_ff, cut_length_in;
   logic             too_long_ff,   too_long_in;

   logic          req_accept;
   logic          nul_accept;
   logic [PW-1:0] ext_pos;
   logic          group_seen;
   logic [PW-1:0] group_start;
   logic          group_hit;
   logic [PW-1:0] group_len;

   // The response register doubles as the skid stage: a new request is taken
   // whenever it is empty or being drained in the same cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign nul_accept    = req_accept && (req_bus.ch == CH_NUL);

   // On the terminator the extension is the last qualifying dot when there is
   // one, otherwise the end of the string. The group must end right at it.
   always_comb begin
      if (dot_valid_ff) begin
         ext_pos     = dot_index_ff;
         group_seen  = dot_has_group_ff;
         group_start = dot_group_start_ff;
      end else begin
         ext_pos     = position_ff;
         group_seen  = closed_just_now_ff;
         group_start = closed_start_ff;
      end
      group_hit = !overflowed_ff && group_seen && (ext_pos > group_start);
      group_len = ext_pos - group_start;
   end

   // Next state of the scan registers.
   always_comb begin
      position_in        = position_ff;
      overflowed_in      = overflowed_ff;
      component_start_in = component_start_ff;
      open_active_in     = open_active_ff;
      open_index_in      = open_index_ff;
      closed_just_now_in = closed_just_now_ff;
      closed_start_in    = closed_start_ff;
      dot_valid_in       = dot_valid_ff;
      dot_has_group_in   = dot_has_group_ff;
      dot_group_start_in = dot_group_start_ff;
      dot_index_in       = dot_index_ff;

      if (nul_accept) begin
         // The terminator reports and then starts a fresh string.
         position_in        = '0;
         overflowed_in      = 1'b0;
         component_start_in = '0;
         open_active_in     = 1'b0;
         open_index_in      = '0;
         closed_just_now_in = 1'b0;
         closed_start_in    = '0;
         dot_valid_in       = 1'b0;
         dot_has_group_in   = 1'b0;
         dot_group_start_in = '0;
         dot_index_in       = '0;
      end else if (req_accept) begin
         if (position_ff >= MAX_POS) begin
            // Too long: the position stays saturated and the byte is dropped.
            overflowed_in = 1'b1;
         end else if (!overflowed_ff) begin
            closed_just_now_in = 1'b0;
            position_in        = position_ff + PW'(1);
            case (req_bus.ch) inside
               CH_OPEN: begin
                  // A bracket on the component's first character never counts.
                  open_active_in = (position_ff > component_start_ff);
                  open_index_in  = position_ff;
               end
               [CH_DIGIT_LO:CH_DIGIT_HI]: begin
                  // Digits keep an open group alive.
               end
               CH_CLOSE: begin
                  closed_just_now_in = open_active_ff;
                  closed_start_in    = open_index_ff;
                  open_active_in     = 1'b0;
               end
               CH_DOT: begin
                  open_active_in     = 1'b0;
                  dot_valid_in       = 1'b1;
                  dot_index_in       = position_ff;
                  dot_has_group_in   = closed_just_now_ff;
                  dot_group_start_in = closed_start_ff;
               end
               CH_SPACE: begin
                  // A space ends the extension search but not the component.
                  open_active_in = 1'b0;
                  dot_valid_in   = 1'b0;
               end
               CH_BACKSLASH: begin
                  open_active_in     = 1'b0;
                  dot_valid_in       = 1'b0;
                  component_start_in = position_ff + PW'(1);
               end
               default: begin
                  open_active_in = 1'b0;
               end
            endcase
         end
      end
   end

   // Next state of the response register. Indices are reported in ten bits.
   always_comb begin
      removed_in    = removed_ff;
      cut_start_in  = cut_start_ff;
      cut_length_in = cut_length_ff;
      too_long_in   = too_long_ff;
      if (nul_accept) begin
         rsp_valid_in  = 1'b1;
         removed_in    = group_hit;
         cut_start_in  = group_hit ? OUT_W'(group_start) : '0;
         cut_length_in = group_hit ? OUT_W'(group_len) : '0;
         too_long_in   = overflowed_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff        <= '0;
         overflowed_ff      <= 1'b0;
         component_start_ff <= '0;
         open_active_ff     <= 1'b0;
         open_index_ff      <= '0;
         closed_just_now_ff <= 1'b0;
         closed_start_ff    <= '0;
         dot_valid_ff       <= 1'b0;
         dot_has_group_ff   <= 1'b0;
         dot_group_start_ff <= '0;
         dot_index_ff       <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         position_ff        <= position_in;
         overflowed_ff      <= overflowed_in;
         component_start_ff <= component_start_in;
         open_active_ff     <= open_active_in;
         open_index_ff      <= open_index_in;
         closed_just_now_ff <= closed_just_now_in;
         closed_start_ff    <= closed_start_in;
         dot_valid_ff       <= dot_valid_in;
         dot_has_group_ff   <= dot_has_group_in;
         dot_group_start_ff <= dot_group_start_in;
         dot_index_ff       <= dot_index_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Response payload needs no reset; it is only looked at under valid.
   always_ff @(posedge clock) begin
      removed_ff    <= removed_in;
      cut_start_ff  <= cut_start_in;
      cut_length_ff <= cut_length_in;
      too_long_ff   <= too_long_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.removed    = removed_ff;
   assign rsp_bus.cut_start  = cut_start_ff;
   assign rsp_bus.cut_length = cut_length_ff;
   assign rsp_bus.too_long   = too_long_ff;

   `PDSF_ASSERT_NEXT(a_nul_gives_rsp, clock, reset, nul_accept,
      rsp_valid_ff && (position_ff == '0) && !overflowed_ff,
      "terminator did not produce a response and clear the scan state")

   `PDSF_ASSERT_NOW(a_overflow_saturated, clock, reset, overflowed_ff,
      position_ff == MAX_POS, "overflow flagged without a saturated position")

   `PDSF_ASSERT_NOW(a_removed_excludes_long, clock, reset, rsp_valid_ff,
      !(removed_ff && too_long_ff), "removal reported on an overlong string")

   `PDSF_ASSERT_NOW(a_open_after_component, clock, reset, open_active_ff,
      open_index_ff > component_start_ff, "open group does not lie past component start")

endmodule
